### sv/mms_pkg.sv
// mms_pkg: command codes and the cell shift control type of the min/max stack.
// No dependencies; imported by mms_cell, min_max_stack and min_max_stack_tb.
`timescale 1ns / 1ps

package mms_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctl_t;

endpackage

### sv/mms_cell.sv
// mms_cell: one level of the min/max stack, holding the running minimum and maximum.
// Depends on mms_pkg for shift_ctl_t.
`timescale 1ns / 1ps

module mms_cell
  import mms_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic                    clk,
  input  shift_ctl_t              ctl,
  input  logic signed [WIDTH-1:0] up_min,
  input  logic signed [WIDTH-1:0] up_max,
  input  logic signed [WIDTH-1:0] dn_min,
  input  logic signed [WIDTH-1:0] dn_max,
  output logic signed [WIDTH-1:0] min_q,
  output logic signed [WIDTH-1:0] max_q
);

  logic signed [WIDTH-1:0] min_r, min_nxt;
  logic signed [WIDTH-1:0] max_r, max_nxt;

  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    if (ctl.push) begin
      min_nxt = up_min;
      max_nxt = up_max;
    end else if (ctl.pop) begin
      min_nxt = dn_min;
      max_nxt = dn_max;
    end
  end

  always_ff @(posedge clk) begin
    min_r <= min_nxt;
    max_r <= max_nxt;
  end

  assign min_q = min_r;
  assign max_q = max_r;

endmodule

### sv/min_max_stack.sv
// min_max_stack: stack of signed values reporting running minimum and maximum on push.
// A push result is registered and valid in the cycle after the request is taken.
// Accepts one request per cycle while out_ready is high; in_ready follows out_ready and the held result.
// Cells shift down on push and up on pop, so the top of stack is always cell 0.
// Reset (synchronous, rst_n low) empties the stack and drops any pending result.
// Depends on mms_pkg and mms_cell.
`timescale 1ns / 1ps

module min_max_stack
  import mms_pkg::*;
#(
  parameter int STACK_DEPTH = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_command,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] out_min_value,
  output logic signed [VALUE_WIDTH-1:0] out_max_value,
  output logic                          out_overflow
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic signed [VALUE_WIDTH-1:0] out_min_r, out_min_nxt;
  logic signed [VALUE_WIDTH-1:0] out_max_r, out_max_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  logic signed [VALUE_WIDTH-1:0] cell_min [STACK_DEPTH];
  logic signed [VALUE_WIDTH-1:0] cell_max [STACK_DEPTH];
  logic signed [VALUE_WIDTH-1:0] new_min, new_max;

  shift_ctl_t ctl;
  logic       accept;
  logic       full;
  logic       empty;
  logic       res_push;
  cmd_t       cmd;

  assign in_ready = rst_n && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == FULL_COUNT);
  assign empty    = (count_r == '0);
  assign cmd      = cmd_t'(in_command);

  always_comb begin
    new_min = in_value;
    new_max = in_value;
    if (!empty) begin
      if (cell_min[0] < in_value) new_min = cell_min[0];
      if (cell_max[0] > in_value) new_max = cell_max[0];
    end
  end

  always_comb begin
    ctl       = '0;
    res_push  = 1'b0;
    count_nxt = count_r;
    if (accept) begin
      case (cmd)
        CMD_PUSH: begin
          res_push = 1'b1;
          if (!full) begin
            ctl.push  = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
        CMD_POP: begin
          if (!empty) begin
            ctl.pop   = 1'b1;
            count_nxt = count_r - CW'(1);
          end
        end
        CMD_CLEAR: count_nxt = '0;
        default: count_nxt = count_r;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_min_nxt   = out_min_r;
    out_max_nxt   = out_max_r;
    out_ovf_nxt   = out_ovf_r;
    if (res_push) begin
      out_valid_nxt = 1'b1;
      if (full) begin
        out_min_nxt = cell_min[0];
        out_max_nxt = cell_max[0];
        out_ovf_nxt = 1'b1;
      end else begin
        out_min_nxt = new_min;
        out_max_nxt = new_max;
        out_ovf_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_min_r <= out_min_nxt;
    out_max_r <= out_max_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  genvar i;
  generate
    for (i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic signed [VALUE_WIDTH-1:0] up_min, up_max, dn_min, dn_max;
      if (i == 0) begin : g_top
        assign up_min = new_min;
        assign up_max = new_max;
      end else begin : g_mid
        assign up_min = cell_min[i-1];
        assign up_max = cell_max[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_bot
        assign dn_min = cell_min[i];
        assign dn_max = cell_max[i];
      end else begin : g_above
        assign dn_min = cell_min[i+1];
        assign dn_max = cell_max[i+1];
      end
      mms_cell #(.WIDTH(VALUE_WIDTH)) u_cell (
        .clk    (clk),
        .ctl    (ctl),
        .up_min (up_min),
        .up_max (up_max),
        .dn_min (dn_min),
        .dn_max (dn_max),
        .min_q  (cell_min[i]),
        .max_q  (cell_max[i])
      );
    end
  endgenerate

  assign out_valid     = out_valid_r;
  assign out_min_value = out_min_r;
  assign out_max_value = out_max_r;
  assign out_overflow  = out_ovf_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("fill count beyond stack depth");

  a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> out_valid_r && (out_ovf_r == $past(full)))
    else $error("push result missing or overflow flag wrong");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |=> count_r == $past(count_r) - CW'(1))
    else $error("pop did not drop fill count by one");

  a_ctl_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.push && ctl.pop))
    else $error("push and pop shift at once");

endmodule

### bench/min_max_stack_tb.sv
// min_max_stack_tb: self-checking bench for the min/max stack, predicting each push report.
// Drives directed, fill-to-overflow, backpressure and random request streams.
// Depends on mms_pkg and min_max_stack.
`timescale 1ns / 1ps

module min_max_stack_tb;
  import mms_pkg::*;

  localparam int STACK_DEPTH = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [VALUE_WIDTH-1:0] MOST_NEGATIVE = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [VALUE_WIDTH-1:0] MOST_POSITIVE = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  typedef struct {
    logic signed [VALUE_WIDTH-1:0] lo;
    logic signed [VALUE_WIDTH-1:0] hi;
    logic                          full;
  } push_report_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [1:0]                    in_command = CMD_PUSH;
  logic signed [VALUE_WIDTH-1:0] in_value = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [VALUE_WIDTH-1:0] out_min_value;
  logic signed [VALUE_WIDTH-1:0] out_max_value;
  logic                          out_overflow;

  logic signed [VALUE_WIDTH-1:0] running_min [STACK_DEPTH];
  logic signed [VALUE_WIDTH-1:0] running_max [STACK_DEPTH];
  int                            stack_fill = 0;
  push_report_t                  pending_reports [$];
  push_report_t                  oldest_report;
  int                            requests_taken = 0;
  int                            mismatches = 0;
  int                            sender_idle_pct = 0;
  int                            receiver_stall_pct = 0;
  int                            hold_left = 0;

  min_max_stack #(
    .STACK_DEPTH(STACK_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_command(in_command),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_min_value(out_min_value),
    .out_max_value(out_max_value),
    .out_overflow(out_overflow)
  );

  always #1 clk = ~clk;

  task automatic track_request(input logic [1:0] cmd,
                               input logic signed [VALUE_WIDTH-1:0] val);
    push_report_t rpt;
    case (cmd)
      CMD_PUSH: begin
        if (stack_fill == STACK_DEPTH) begin
          rpt.lo = running_min[STACK_DEPTH-1];
          rpt.hi = running_max[STACK_DEPTH-1];
          rpt.full = 1'b1;
        end else begin
          rpt.lo = val;
          rpt.hi = val;
          rpt.full = 1'b0;
          if (stack_fill > 0) begin
            if (running_min[stack_fill-1] < rpt.lo) rpt.lo = running_min[stack_fill-1];
            if (running_max[stack_fill-1] > rpt.hi) rpt.hi = running_max[stack_fill-1];
          end
          running_min[stack_fill] = rpt.lo;
          running_max[stack_fill] = rpt.hi;
          stack_fill++;
        end
        pending_reports.insert(pending_reports.size(), rpt);
      end
      CMD_POP: begin
        if (stack_fill > 0) stack_fill--;
      end
      CMD_CLEAR: begin
        stack_fill = 0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        track_request(in_command, in_value);
        requests_taken++;
      end
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: unexpected result min=%0d max=%0d overflow=%b",
                   $time, out_min_value, out_max_value, out_overflow);
          mismatches++;
        end else begin
          oldest_report = pending_reports.pop_front();
          if (out_min_value !== oldest_report.lo || out_max_value !== oldest_report.hi ||
              out_overflow !== oldest_report.full) begin
            $display("%0t: expected min=%0d max=%0d overflow=%b, got min=%0d max=%0d overflow=%b",
                     $time, oldest_report.lo, oldest_report.hi, oldest_report.full,
                     out_min_value, out_max_value, out_overflow);
            mismatches++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
    case ($urandom_range(9))
      0: pick_value = MOST_NEGATIVE;
      1: pick_value = MOST_POSITIVE;
      2: pick_value = '0;
      3: pick_value = '1;
      4, 5: pick_value = $urandom_range(15) - 8;
      default: pick_value = $urandom;
    endcase
  endfunction

  task automatic send_request(input logic [1:0] cmd,
                              input logic signed [VALUE_WIDTH-1:0] val);
    int gap;
    int target;
    gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_value <= val;
    target = requests_taken + 1;
    do @(negedge clk); while (requests_taken < target);
  endtask

  task automatic test_directed();
    sender_idle_pct = 10;
    receiver_stall_pct = 55;
    send_request(CMD_POP, '0);
    send_request(CMD_UNUSED, MOST_POSITIVE);
    send_request(CMD_PUSH, '0);
    send_request(CMD_PUSH, MOST_POSITIVE);
    send_request(CMD_PUSH, MOST_NEGATIVE);
    send_request(CMD_PUSH, '1);
    send_request(CMD_PUSH, 1);
    send_request(CMD_POP, MOST_NEGATIVE);
    send_request(CMD_POP, '1);
    send_request(CMD_PUSH, 5);
    send_request(CMD_CLEAR, MOST_POSITIVE);
    send_request(CMD_POP, '0);
    send_request(CMD_PUSH, -5);
    send_request(CMD_PUSH, 3);
    send_request(CMD_UNUSED, MOST_NEGATIVE);
    send_request(CMD_POP, '0);
    send_request(CMD_POP, '0);
    send_request(CMD_POP, '0);
    send_request(CMD_PUSH, MOST_NEGATIVE);
    send_request(CMD_PUSH, MOST_NEGATIVE);
    send_request(CMD_POP, '0);
    send_request(CMD_PUSH, MOST_POSITIVE);
    send_request(CMD_CLEAR, '0);
  endtask

  task automatic test_fill_to_overflow();
    sender_idle_pct = 10;
    receiver_stall_pct = 55;
    send_request(CMD_CLEAR, '0);
    repeat (STACK_DEPTH + 2) send_request(CMD_PUSH, pick_value());
    send_request(CMD_POP, pick_value());
    repeat (2) send_request(CMD_PUSH, pick_value());
    repeat (3) send_request(CMD_POP, pick_value());
    send_request(CMD_CLEAR, pick_value());
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_left = 300;
    repeat (20) send_request(CMD_PUSH, pick_value());
    repeat (8) send_request(CMD_POP, pick_value());
  endtask

  task automatic test_random(input int sender_pct, input int receiver_pct, input int count);
    int sent;
    int pick;
    sender_idle_pct = sender_pct;
    receiver_stall_pct = receiver_pct;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 58) begin
        send_request(CMD_PUSH, pick_value());
      end else if (pick < 90) begin
        send_request(CMD_POP, pick_value());
      end else if (pick < 94) begin
        send_request(CMD_CLEAR, pick_value());
      end else begin
        send_request(CMD_UNUSED, pick_value());
      end
      sent++;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_fill_to_overflow();
    test_backpressure();
    test_random(10, 55, 20);
    test_random(55, 10, 20);
    test_random(0, 0, 20);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### min_max_stack.f
sv/mms_pkg.sv
sv/mms_cell.sv
sv/min_max_stack.sv
bench/min_max_stack_tb.sv
